>>> rtl/msc_pkg.sv
package msc_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int VALUE_WIDTH  = 32;

   localparam int ADDR_W      = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int COUNT_W     = $clog2(MAX_ELEMENTS + 1);
   localparam int CNT_W       = 12;
   localparam int STACK_DEPTH = $clog2(MAX_ELEMENTS);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int SP_IDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   typedef logic [ADDR_W-1:0]      addr_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [CNT_W-1:0]       cnt_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               end_of_set;
      cnt_type            comparisons;
      logic               overflowed;
   } rsp_type;

   typedef struct packed {
      logic      we;
      addr_type  waddr;
      value_type wdata;
      addr_type  raddr;
   } elem_req_type;

   typedef struct packed {
      logic      we;
      addr_type  waddr;
      value_type wdata;
      addr_type  raddr_a;
      addr_type  raddr_b;
   } scr_req_type;

   typedef struct packed {
      logic    done;
      cnt_type comparisons;
   } sort_status_type;

   function automatic value_type to_store(input logic [31:0] v);
      logic signed [63:0] e;
      e = 64'($signed(v));
      return e[VALUE_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] from_store(input value_type s);
      logic signed [63:0] e;
      e = 64'($signed(s));
      return e[31:0];
   endfunction

endpackage

>>> rtl/merge_sort_counted_unit.sv
// Loading: one beat per cycle while busy is low; a set of N values is sorted after the is_last beat.
// Sort: copy and merge passes over the element and scratch memories (one element per cycle per pass);
// results are then read from the element memory and registered before rsp_strobe.
// Output: N results on consecutive cycles.
// Reset (synchronous): clears counts, flags and control; memories are not cleared. No rsp stall.
module merge_sort_counted_unit
   import msc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   typedef enum logic [1:0] {ST_LOAD, ST_SORT, ST_EMIT, ST_FLUSH} state_type;

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   logic      ovf_ff, ovf_in;
   addr_type  emit_ptr_ff, emit_ptr_in;
   logic      emit_v_ff, emit_v_in;
   logic      emit_last_ff, emit_last_in;
   logic      rsp_v_ff, rsp_v_in;
   rsp_type   rsp_ff, rsp_in;

   logic            accept, room, emit_last;
   elem_req_type    top_req, sort_elem_req, elem_req;
   scr_req_type     scr_req;
   value_type       elem_rdata, scr_rdata_a, scr_rdata_b;
   sort_status_type sort_status;
   logic            sort_start;

   msc_sorter u_sorter (
      .clock       (clock),
      .reset       (reset),
      .start       (sort_start),
      .n           (count_in),
      .elem_rdata  (elem_rdata),
      .scr_rdata_a (scr_rdata_a),
      .scr_rdata_b (scr_rdata_b),
      .elem_req    (sort_elem_req),
      .scr_req     (scr_req),
      .status      (sort_status)
   );

   msc_store u_store (
      .clock       (clock),
      .elem_req    (elem_req),
      .scr_req     (scr_req),
      .elem_rdata  (elem_rdata),
      .scr_rdata_a (scr_rdata_a),
      .scr_rdata_b (scr_rdata_b)
   );

   always_comb begin
      busy      = (state_ff != ST_LOAD);
      accept    = start && !busy;
      room      = count_ff < COUNT_W'(MAX_ELEMENTS);
      emit_last = (COUNT_W'(emit_ptr_ff) + COUNT_W'(1)) == count_ff;

      top_req.we    = accept && room;
      top_req.waddr = count_ff[ADDR_W-1:0];
      top_req.wdata = to_store(req_item.value);
      top_req.raddr = emit_ptr_ff;
      elem_req      = (state_ff == ST_SORT) ? sort_elem_req : top_req;

      state_in    = state_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      emit_ptr_in = emit_ptr_ff;
      sort_start  = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  count_in = count_ff + COUNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_item.is_last) begin
                  sort_start = 1'b1;
                  state_in   = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            if (sort_status.done) begin
               emit_ptr_in = '0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_last) begin
               state_in = ST_FLUSH;
            end else begin
               emit_ptr_in = emit_ptr_ff + ADDR_W'(1);
            end
         end
         ST_FLUSH: begin
            count_in = '0;
            ovf_in   = 1'b0;
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      emit_v_in    = (state_ff == ST_EMIT);
      emit_last_in = (state_ff == ST_EMIT) && emit_last;

      rsp_v_in            = emit_v_ff;
      rsp_in.sorted_value = from_store(elem_rdata);
      rsp_in.end_of_set   = emit_last_ff;
      rsp_in.comparisons  = sort_status.comparisons;
      rsp_in.overflowed   = ovf_ff;
   end

   always_ff @(posedge clock) begin
      emit_ptr_ff  <= emit_ptr_in;
      emit_last_ff <= emit_last_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         emit_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         emit_v_ff <= emit_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   assign rsp_strobe = rsp_v_ff;
   assign rsp_item   = rsp_ff;

   a_set_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_ff.end_of_set |=> !rsp_v_ff)
      else $error("beat after end of set");

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      emit_v_ff |-> busy)
      else $error("load reopened with results in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_ELEMENTS))
      else $error("element count beyond capacity");

endmodule

>>> rtl/msc_store.sv
module msc_store
   import msc_pkg::*;
(
   input  logic         clock,
   input  elem_req_type elem_req,
   input  scr_req_type  scr_req,
   output value_type    elem_rdata,
   output value_type    scr_rdata_a,
   output value_type    scr_rdata_b
);

   value_type elem_mem [MAX_ELEMENTS];
   value_type scr_mem  [MAX_ELEMENTS];
   value_type elem_rdata_ff;
   value_type scr_rdata_a_ff;
   value_type scr_rdata_b_ff;

   always_ff @(posedge clock) begin
      if (elem_req.we) begin
         elem_mem[elem_req.waddr] <= elem_req.wdata;
      end
      elem_rdata_ff <= elem_mem[elem_req.raddr];
   end

   always_ff @(posedge clock) begin
      if (scr_req.we) begin
         scr_mem[scr_req.waddr] <= scr_req.wdata;
      end
      scr_rdata_a_ff <= scr_mem[scr_req.raddr_a];
      scr_rdata_b_ff <= scr_mem[scr_req.raddr_b];
   end

   assign elem_rdata  = elem_rdata_ff;
   assign scr_rdata_a = scr_rdata_a_ff;
   assign scr_rdata_b = scr_rdata_b_ff;

endmodule

>>> rtl/msc_sorter.sv
module msc_sorter
   import msc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  count_type       n,
   input  value_type       elem_rdata,
   input  value_type       scr_rdata_a,
   input  value_type       scr_rdata_b,
   output elem_req_type    elem_req,
   output scr_req_type     scr_req,
   output sort_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DISPATCH, ST_COPY, ST_DRAIN, ST_PRIME, ST_MERGE
   } state_type;

   typedef enum logic [1:0] {PH_LEFT, PH_RIGHT, PH_MERGE} phase_type;

   typedef struct packed {
      addr_type  lo;
      addr_type  hi;
      phase_type phase;
   } frame_type;

   state_type state_ff, state_in;
   frame_type stack_ff [STACK_DEPTH];
   frame_type stack_in [STACK_DEPTH];
   logic [SP_W-1:0] sp_ff, sp_in;
   addr_type  cur_lo_ff, cur_lo_in, cur_md_ff, cur_md_in, cur_hi_ff, cur_hi_in;
   addr_type  rd_ptr_ff, rd_ptr_in;
   logic      cp_v_ff, cp_v_in;
   addr_type  cp_addr_ff, cp_addr_in;
   addr_type  l_ff, l_in, k_ff, k_in;
   count_type r_ff, r_in;
   cnt_type   cmp_ff, cmp_in;
   logic      done_ff, done_in;

   logic [SP_IDX_W-1:0] top_idx, push_idx;
   frame_type top;
   logic [ADDR_W:0] mid_sum;
   addr_type  top_md;
   logic      lv, rv, take_r;

   always_comb begin
      top_idx  = SP_IDX_W'(sp_ff - SP_W'(1));
      push_idx = SP_IDX_W'(sp_ff);
      top      = stack_ff[top_idx];
      mid_sum  = {1'b0, top.lo} + {1'b0, top.hi};
      top_md   = mid_sum[ADDR_W:1];
      lv       = l_ff <= cur_md_ff;
      rv       = r_ff <= COUNT_W'(cur_hi_ff);
      take_r   = rv && (!lv || ($signed(scr_rdata_a) > $signed(scr_rdata_b)));

      state_in   = state_ff;
      stack_in   = stack_ff;
      sp_in      = sp_ff;
      cur_lo_in  = cur_lo_ff;
      cur_md_in  = cur_md_ff;
      cur_hi_in  = cur_hi_ff;
      rd_ptr_in  = rd_ptr_ff;
      cp_v_in    = (state_ff == ST_COPY);
      cp_addr_in = rd_ptr_ff;
      l_in       = l_ff;
      r_in       = r_ff;
      k_in       = k_ff;
      cmp_in     = cmp_ff;
      done_in    = 1'b0;

      elem_req.we    = 1'b0;
      elem_req.waddr = k_ff;
      elem_req.wdata = take_r ? scr_rdata_b : scr_rdata_a;
      elem_req.raddr = rd_ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmp_in      = '0;
               sp_in       = (n > COUNT_W'(1)) ? SP_W'(1) : '0;
               stack_in[0] = '{lo: '0, hi: ADDR_W'(n - COUNT_W'(1)), phase: PH_LEFT};
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sp_ff == '0) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               unique case (top.phase)
                  PH_LEFT: begin
                     stack_in[top_idx].phase = PH_RIGHT;
                     if (top.lo != top_md) begin
                        stack_in[push_idx] = '{lo: top.lo, hi: top_md, phase: PH_LEFT};
                        sp_in = sp_ff + SP_W'(1);
                     end
                  end
                  PH_RIGHT: begin
                     stack_in[top_idx].phase = PH_MERGE;
                     if (ADDR_W'(top_md + ADDR_W'(1)) != top.hi) begin
                        stack_in[push_idx] =
                           '{lo: ADDR_W'(top_md + ADDR_W'(1)), hi: top.hi, phase: PH_LEFT};
                        sp_in = sp_ff + SP_W'(1);
                     end
                  end
                  PH_MERGE: begin
                     cur_lo_in = top.lo;
                     cur_md_in = top_md;
                     cur_hi_in = top.hi;
                     rd_ptr_in = top.lo;
                     state_in  = ST_COPY;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_COPY: begin
            if (rd_ptr_ff == cur_hi_ff) begin
               state_in = ST_DRAIN;
            end else begin
               rd_ptr_in = rd_ptr_ff + ADDR_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_PRIME;
         end
         ST_PRIME: begin
            l_in     = cur_lo_ff;
            r_in     = COUNT_W'(cur_md_ff) + COUNT_W'(1);
            k_in     = cur_lo_ff;
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            elem_req.we = 1'b1;
            if (take_r) begin
               r_in = r_ff + COUNT_W'(1);
            end else begin
               l_in = l_ff + ADDR_W'(1);
            end
            if (lv && rv) begin
               cmp_in = cmp_ff + CNT_W'(1);
            end
            if (k_ff == cur_hi_ff) begin
               sp_in    = sp_ff - SP_W'(1);
               state_in = ST_DISPATCH;
            end else begin
               k_in = k_ff + ADDR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      scr_req.we      = cp_v_ff;
      scr_req.waddr   = cp_addr_ff;
      scr_req.wdata   = elem_rdata;
      scr_req.raddr_a = l_in;
      scr_req.raddr_b = r_in[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      stack_ff   <= stack_in;
      cur_lo_ff  <= cur_lo_in;
      cur_md_ff  <= cur_md_in;
      cur_hi_ff  <= cur_hi_in;
      rd_ptr_ff  <= rd_ptr_in;
      cp_addr_ff <= cp_addr_in;
      l_ff       <= l_in;
      r_ff       <= r_in;
      k_ff       <= k_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= '0;
         cp_v_ff  <= 1'b0;
         cmp_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         cp_v_ff  <= cp_v_in;
         cmp_ff   <= cmp_in;
         done_ff  <= done_in;
      end
   end

   assign status.done        = done_ff;
   assign status.comparisons = cmp_ff;

   // one merge frame per halving level
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("merge stack overrun");

   // every output slot consumes exactly one element from one half
   a_merge_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |->
         (COUNT_W + 1)'(k_ff) + (COUNT_W + 1)'(cur_md_ff) + (COUNT_W + 1)'(1)
         == (COUNT_W + 1)'(l_ff) + (COUNT_W + 1)'(r_ff))
      else $error("merge pointers out of step");

   a_merge_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |->
         (COUNT_W'(l_ff) <= COUNT_W'(cur_md_ff) + COUNT_W'(1))
         && (r_ff <= COUNT_W'(cur_hi_ff) + COUNT_W'(1)))
      else $error("merge pointer past its half");

   a_copy_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PRIME |-> !cp_v_ff)
      else $error("scratch read primed before copy finished");

endmodule
